>>> rtl/hsv_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the HSV to RGB converter.
// Used by the hue-reduce, level-calc and top-level modules; depends on nothing else.
package hsv_pkg;

  localparam logic [8:0] HUE_FULL = 9'd360;
  localparam logic [9:0] HUE_RECIP = 10'd728;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned PROD_W = 26;
  localparam logic [5:0] SECTOR_SPAN = 6'd60;
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic [7:0] ROUND_HALF = 8'd128;

  typedef enum logic [2:0] {
    SECTOR_0,
    SECTOR_1,
    SECTOR_2,
    SECTOR_3,
    SECTOR_4,
    SECTOR_5
  } sector_t;

  typedef struct packed {
    logic       valid;
    sector_t    sector;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
  } sect_beat_t;

  // Exact floor(x / 255) for any 16-bit x whose quotient is at most 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // Rounded scale of the in-sector remainder to 0..255: floor(4.25 * rem + 0.5).
  function automatic logic [7:0] frac_of_rem(input logic [5:0] rem);
    logic [9:0] scaled;
    scaled = {rem, 4'b0000} + {4'b0000, rem} + 10'd2;
    return scaled[9:2];
  endfunction

endpackage

>>> rtl/hsv_hue_reduce.sv
`timescale 1ns / 1ps
// Hue front end: reduces hue modulo 360, then finds the sector and fraction.
// Three register stages; depends on hsv_pkg.
module hsv_hue_reduce (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [15:0]             hue,
  input  logic [7:0]              saturation,
  input  logic [7:0]              brightness,
  output hsv_pkg::sect_beat_t     sect_beat
);

  logic [hsv_pkg::PROD_W-1:0] recip_prod;
  logic       s1_valid;
  logic [15:0] s1_hue;
  logic [7:0] s1_quot;
  logic [7:0] s1_sat;
  logic [7:0] s1_val;

  logic [16:0] s2_base;
  logic [16:0] s2_diff;
  logic [8:0]  s2_h_next;
  logic        s2_valid;
  logic [8:0]  s2_h;
  logic [7:0]  s2_sat;
  logic [7:0]  s2_val;

  hsv_pkg::sector_t s3_sector_next;
  logic [8:0]       s3_start;
  logic [8:0]       s3_rem_full;
  hsv_pkg::sect_beat_t s3_beat;

  assign recip_prod = hsv_pkg::PROD_W'(hue) * hsv_pkg::PROD_W'(hsv_pkg::HUE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_hue  <= hue;
    s1_quot <= recip_prod[hsv_pkg::PROD_W-1:hsv_pkg::RECIP_SHIFT];
    s1_sat  <= saturation;
    s1_val  <= brightness;
  end

  // The estimated quotient is exact or one short, so one correction suffices.
  always_comb begin
    s2_base = 17'(s1_quot) * 17'(hsv_pkg::HUE_FULL);
    s2_diff = {1'b0, s1_hue} - s2_base;
    if (s2_diff[9:0] >= {1'b0, hsv_pkg::HUE_FULL}) begin
      s2_h_next = 9'(s2_diff[9:0] - {1'b0, hsv_pkg::HUE_FULL});
    end else begin
      s2_h_next = s2_diff[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_h   <= s2_h_next;
    s2_sat <= s1_sat;
    s2_val <= s1_val;
  end

  always_comb begin
    if (s2_h >= 9'd300) begin
      s3_sector_next = hsv_pkg::SECTOR_5;
      s3_start = 9'd300;
    end else if (s2_h >= 9'd240) begin
      s3_sector_next = hsv_pkg::SECTOR_4;
      s3_start = 9'd240;
    end else if (s2_h >= 9'd180) begin
      s3_sector_next = hsv_pkg::SECTOR_3;
      s3_start = 9'd180;
    end else if (s2_h >= 9'd120) begin
      s3_sector_next = hsv_pkg::SECTOR_2;
      s3_start = 9'd120;
    end else if (s2_h >= {3'd0, hsv_pkg::SECTOR_SPAN}) begin
      s3_sector_next = hsv_pkg::SECTOR_1;
      s3_start = {3'd0, hsv_pkg::SECTOR_SPAN};
    end else begin
      s3_sector_next = hsv_pkg::SECTOR_0;
      s3_start = 9'd0;
    end
    s3_rem_full = s2_h - s3_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_beat.valid <= 1'b0;
    end else begin
      s3_beat.valid <= s2_valid;
    end
    s3_beat.sector <= s3_sector_next;
    s3_beat.frac   <= hsv_pkg::frac_of_rem(s3_rem_full[5:0]);
    s3_beat.sat    <= s2_sat;
    s3_beat.val    <= s2_val;
  end

  assign sect_beat = s3_beat;

endmodule

>>> rtl/hsv_level_calc.sv
`timescale 1ns / 1ps
// Level back end: forms p, q and t and routes them to the channels by sector.
// Four register stages, the last being the output register; depends on hsv_pkg.
module hsv_level_calc (
  input  logic                clk,
  input  logic                rst,
  input  hsv_pkg::sect_beat_t sect_beat,
  output logic                out_valid,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);

  logic             s4_valid;
  hsv_pkg::sector_t s4_sector;
  logic [7:0]       s4_val;
  logic [15:0]      s4_sf;
  logic [15:0]      s4_sft;
  logic [15:0]      s4_pp;

  logic             s5_valid;
  hsv_pkg::sector_t s5_sector;
  logic [7:0]       s5_val;
  logic [7:0]       s5_p;
  logic [7:0]       s5_qa;
  logic [7:0]       s5_ta;

  logic             s6_valid;
  hsv_pkg::sector_t s6_sector;
  logic [7:0]       s6_val;
  logic [7:0]       s6_p;
  logic [15:0]      s6_qp;
  logic [15:0]      s6_tp;

  logic [7:0] q_lvl;
  logic [7:0] t_lvl;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= sect_beat.valid;
    end
    s4_sector <= sect_beat.sector;
    s4_val    <= sect_beat.val;
    s4_sf     <= 16'(sect_beat.sat) * 16'(sect_beat.frac);
    s4_sft    <= 16'(sect_beat.sat) * 16'(hsv_pkg::LEVEL_MAX - sect_beat.frac);
    s4_pp     <= 16'(sect_beat.val) * 16'(hsv_pkg::LEVEL_MAX - sect_beat.sat)
                 + 16'(hsv_pkg::ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_sector <= s4_sector;
    s5_val    <= s4_val;
    s5_p      <= hsv_pkg::div255(s4_pp);
    s5_qa     <= hsv_pkg::LEVEL_MAX
                 - hsv_pkg::div255(s4_sf + 16'(hsv_pkg::ROUND_HALF));
    s5_ta     <= hsv_pkg::LEVEL_MAX - hsv_pkg::div255(s4_sft);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_sector <= s5_sector;
    s6_val    <= s5_val;
    s6_p      <= s5_p;
    s6_qp     <= 16'(s5_val) * 16'(s5_qa) + 16'(hsv_pkg::ROUND_HALF);
    s6_tp     <= 16'(s5_val) * 16'(s5_ta);
  end

  always_comb begin
    q_lvl = hsv_pkg::div255(s6_qp);
    t_lvl = hsv_pkg::div255(s6_tp);
    case (s6_sector)
      hsv_pkg::SECTOR_0: begin
        red_next = s6_val; green_next = t_lvl; blue_next = s6_p;
      end
      hsv_pkg::SECTOR_1: begin
        red_next = q_lvl; green_next = s6_val; blue_next = s6_p;
      end
      hsv_pkg::SECTOR_2: begin
        red_next = s6_p; green_next = s6_val; blue_next = t_lvl;
      end
      hsv_pkg::SECTOR_3: begin
        red_next = s6_p; green_next = q_lvl; blue_next = s6_val;
      end
      hsv_pkg::SECTOR_4: begin
        red_next = t_lvl; green_next = s6_p; blue_next = s6_val;
      end
      default: begin
        red_next = s6_val; green_next = s6_p; blue_next = q_lvl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s6_valid;
    end
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

>>> rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// Each accepted beat runs through the hue-reduce and level-calc register stages to its result beat.
// Throughput is one beat per cycle; busy is always low, so start may stay high.
// Depth is set by the two multiply and divide-by-255 passes and the hue reduction.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous reset clears all pipeline valid bits; data registers are not reset.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        strobe,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  hsv_pkg::sect_beat_t sect_beat;
  logic in_valid;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  hsv_hue_reduce u_hue_reduce (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .sect_beat  (sect_beat)
  );

  hsv_level_calc u_level_calc (
    .clk       (clk),
    .rst       (rst),
    .sect_beat (sect_beat),
    .out_valid (strobe),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

>>> rtl/hsv_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Sees only the top-level ports; depends on nothing else.
module hsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [7:0]  saturation,
  input logic [7:0]  brightness,
  input logic        strobe,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy was raised");

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 strobe)
    else $error("accepted beat gave no result");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##7 !strobe)
    else $error("result strobe without an accepted beat");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && saturation == 8'd0) |->
      ##7 (red == $past(brightness, 7) && green == red && blue == red))
    else $error("zero saturation did not give grey");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .saturation (saturation),
  .brightness (brightness),
  .strobe     (strobe),
  .red        (red),
  .green      (green),
  .blue       (blue)
);
